/* sv/aes128_pkg.sv */
// shared types, constants and gf/sbox functions for the aes-128 block
`default_nettype none
package aes128_pkg;

  localparam int unsigned Rounds    = 10;
  localparam int unsigned SchedWords = 4 * (Rounds + 1);

  localparam logic CfgKeyUpper = 1'b0;
  localparam logic CfgKeyLower = 1'b1;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [7:0] byte_t;

  function automatic byte_t fwd_sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[x];
  endfunction

  function automatic byte_t inv_sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };
    return t[x];
  endfunction

  function automatic byte_t xt(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

/* sv/aes128_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module aes128_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* sv/aes128_round.sv */
// one shared round unit: forward or inverse round on the 128-bit state
`default_nettype none
module aes128_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic         decrypt_i,
  input  wire logic         mix_i,
  output      logic [127:0] state_o
);
  // byte 0 of the block sits in bits 127:120
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] u [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, b2, b4, b8, c2, c4, c8, d2, d4, d8, e2, e4, e8;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt_i) begin
          t[4*c+r] = aes128_pkg::inv_sbox(s[4*((c+4-r)%4)+r]);
        end else begin
          t[4*c+r] = aes128_pkg::fwd_sbox(s[4*((c+r)%4)+r]);
        end
      end
    end
    // inverse cipher adds the key before inverse mix
    for (int i = 0; i < 16; i++) begin
      u[i] = decrypt_i ? (t[i] ^ rkey_i[127-8*i -: 8]) : t[i];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
      if (decrypt_i) begin
        b2 = aes128_pkg::xt(a0); b4 = aes128_pkg::xt(b2); b8 = aes128_pkg::xt(b4);
        c2 = aes128_pkg::xt(a1); c4 = aes128_pkg::xt(c2); c8 = aes128_pkg::xt(c4);
        d2 = aes128_pkg::xt(a2); d4 = aes128_pkg::xt(d2); d8 = aes128_pkg::xt(d4);
        e2 = aes128_pkg::xt(a3); e4 = aes128_pkg::xt(e2); e8 = aes128_pkg::xt(e4);
        m[4*c]   = (b8^b4^b2) ^ (c8^c2^a1) ^ (d8^d4^a2) ^ (e8^a3);
        m[4*c+1] = (b8^a0) ^ (c8^c4^c2) ^ (d8^d2^a2) ^ (e8^e4^a3);
        m[4*c+2] = (b8^b4^a0) ^ (c8^a1) ^ (d8^d4^d2) ^ (e8^e2^a3);
        m[4*c+3] = (b8^b2^a0) ^ (c8^c4^a1) ^ (d8^a2) ^ (e8^e4^e2);
      end else begin
        b2 = aes128_pkg::xt(a0); c2 = aes128_pkg::xt(a1);
        d2 = aes128_pkg::xt(a2); e2 = aes128_pkg::xt(a3);
        b4 = 8'h00; b8 = 8'h00; c4 = 8'h00; c8 = 8'h00;
        d4 = 8'h00; d8 = 8'h00; e4 = 8'h00; e8 = 8'h00;
        m[4*c]   = b2 ^ c2 ^ a1 ^ a2 ^ a3;
        m[4*c+1] = a0 ^ c2 ^ d2 ^ a2 ^ a3;
        m[4*c+2] = a0 ^ a1 ^ d2 ^ e2 ^ a3;
        m[4*c+3] = b2 ^ a0 ^ a1 ^ a2 ^ e2;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (decrypt_i) begin
        state_o[127-8*i -: 8] = mix_i ? m[i] : u[i];
      end else begin
        state_o[127-8*i -: 8] = (mix_i ? m[i] : u[i]) ^ rkey_i[127-8*i -: 8];
      end
    end
  end
endmodule
`default_nettype wire

/* sv/aes128_block_cipher_top.sv */
// aes-128 ecb block cipher: key schedule, round-key memory and round sequencer
// usage:
//   cfg channel writes key_upper (index 0) or key_lower (index 1); either
//   write marks the round-key table stale. write only while idle.
//   s_axis request: tuser = operation (0 encrypt, 1 decrypt), tdata = block.
//   m_axis request: tdata = processed block, one per input request.
// sequencing:
//   each of the eleven key additions reads the round key one 32-bit word
//   at a time from the memory, then applies the round. after a key change
//   the first block first expands the key, one word per cycle through the
//   same memory port, before its key additions begin.
//   s_axis_tready is high only in idle, which is reached the cycle after the
//   result is taken: a new block is taken only once the last one has left.
// reset: keys clear to zero and the schedule is marked stale.
// stall: the result holds on m_axis_tdata until m_axis_tready is high;
//   until then no new block is taken.
`default_nettype none
module aes128_block_cipher_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // block_upper, block_lower
  input  wire logic         s_axis_tuser,  // operation
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [127:0] m_axis_tdata   // result_upper, result_lower
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]   st_q, st_d;
  logic [63:0]  key_hi_q, key_lo_q;
  logic         sched_ok_q;
  logic         dec_q;
  logic [127:0] state_q, state_d;  // byte 0 of the block in bits 127:120
  logic [95:0]  rk_q;  // round-key words 0..2; word 3 comes straight from the memory
  logic [5:0]   cnt_q, cnt_d;  // expansion word / fetch word counter
  logic [3:0]   rnd_q, rnd_d;
  logic [1:0]   wsel_q;
  logic         rd_pend_q;
  logic [127:0] hist_q;  // last four expanded words, oldest high
  logic [31:0]  rcon_q;

  logic         we;
  logic [5:0]   addr;
  logic [31:0]  wdata, rdata, tw;
  logic [127:0] rnd_out;
  logic [127:0] rk_full;

  assign rk_full = {rk_q, rdata};

  aes128_ram #(.Width(32), .Depth(aes128_pkg::SchedWords)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  aes128_round u_round (
    .state_i(state_q), .rkey_i(rk_full), .decrypt_i(dec_q),
    .mix_i(rnd_q != 4'(aes128_pkg::Rounds)), .state_o(rnd_out)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = {state_q[63:0], state_q[127:64]};

  // next expanded word from the previous four
  always_comb begin
    tw = hist_q[31:0];
    if (cnt_q[1:0] == 2'd0) begin
      tw = aes128_pkg::sbox_word({tw[23:0], tw[31:24]}) ^ rcon_q;
    end
  end

  // round index -> memory word; decrypt walks rounds downward
  logic [3:0] krnd;
  always_comb begin
    krnd = dec_q ? 4'(4'(aes128_pkg::Rounds) - rnd_q) : rnd_q;
    we    = 1'b0;
    wdata = 32'h0;
    addr  = {krnd, 2'b00} + 6'(cnt_q[1:0]);
    if (st_q == StExp) begin
      we = 1'b1;
      if (cnt_q < 6'd4) begin
        wdata = cnt_q[1] ? (cnt_q[0] ? key_lo_q[31:0] : key_lo_q[63:32])
                         : (cnt_q[0] ? key_hi_q[31:0] : key_hi_q[63:32]);
      end else begin
        wdata = hist_q[127:96] ^ tw;
      end
      addr = cnt_q;
    end
  end

  always_comb begin
    st_d = st_q; state_d = state_q; cnt_d = cnt_q; rnd_d = rnd_q;
    case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
          cnt_d = 6'd0;
          rnd_d = 4'd0;
          st_d = sched_ok_q ? StLoad : StExp;
        end
      end
      StExp: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(aes128_pkg::SchedWords - 1)) begin
          cnt_d = 6'd0;
          st_d = StLoad;
        end
      end
      StLoad, StRnd: begin
        // issue reads for words 0..3 of the current round; apply when gathered
        if (cnt_q[2]) begin
          if (rnd_q == 4'd0) begin
            state_d = state_q ^ rk_full;
          end else begin
            state_d = rnd_out;
          end
          cnt_d = 6'd0;
          if (rnd_q == 4'(aes128_pkg::Rounds)) begin
            st_d = StOut;
          end else begin
            rnd_d = rnd_q + 4'd1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      StOut: begin
        if (m_axis_tready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      key_hi_q <= 64'h0;
      key_lo_q <= 64'h0;
      sched_ok_q <= 1'b0;
      cnt_q <= 6'd0;
      rnd_q <= 4'd0;
      rd_pend_q <= 1'b0;
      wsel_q <= 2'd0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      rnd_q <= rnd_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == aes128_pkg::CfgKeyUpper) key_hi_q <= cfg_data_i;
        else key_lo_q <= cfg_data_i;
        sched_ok_q <= 1'b0;
      end else if (st_q == StExp && st_d == StLoad) begin
        sched_ok_q <= 1'b1;
      end
      rd_pend_q <= (st_q == StLoad || st_q == StRnd) && !cnt_q[2];
      wsel_q <= cnt_q[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    if (st_q == StIdle) begin
      dec_q <= (s_axis_tuser == aes128_pkg::OpDecrypt);
      rcon_q <= 32'h01000000;
    end
    if (st_q == StExp) begin
      hist_q <= {hist_q[95:0], wdata};
      if (cnt_q >= 6'd4 && cnt_q[1:0] == 2'd0) begin
        rcon_q <= {aes128_pkg::xt(rcon_q[31:24]), 24'h0};
      end
    end
    if (rd_pend_q && wsel_q != 2'd3) begin
      rk_q[95-32*wsel_q -: 32] <= rdata;
    end
  end
endmodule
`default_nettype wire

/* tb/aes128_cipher_checker.sv */
// channel monitor for the aes-128 block: predicts every result and compares it
`default_nettype none
module aes128_cipher_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_i,
  input  wire logic         cfg_index_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [127:0] s_tdata_i,
  input  wire logic         s_tuser_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [127:0] m_tdata_i,
  output int                errors_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
  } cipher_block_t;

  aes128_pkg::byte_t sbox_fwd [256];
  aes128_pkg::byte_t sbox_rev [256];
  logic [63:0]       key_hi, key_lo;
  logic [31:0]       round_keys [aes128_pkg::SchedWords];
  cipher_block_t     block_q [$];

  function automatic aes128_pkg::byte_t gmul(input aes128_pkg::byte_t a,
                                             input aes128_pkg::byte_t b);
    aes128_pkg::byte_t acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return acc;
  endfunction

  // sbox from the multiplicative inverse followed by the affine map
  initial begin
    aes128_pkg::byte_t inv, y;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int c = 1; c < 256; c++)
        if (gmul(8'(x), 8'(c)) == 8'h01) inv = 8'(c);
      y = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_fwd[x] = y;
      sbox_rev[y] = 8'(x);
    end
  end

  function automatic void build_round_keys();
    logic [31:0] t;
    aes128_pkg::byte_t rc;
    rc = 8'h01;
    round_keys[0] = key_hi[63:32];
    round_keys[1] = key_hi[31:0];
    round_keys[2] = key_lo[63:32];
    round_keys[3] = key_lo[31:0];
    for (int i = 4; i < aes128_pkg::SchedWords; i++) begin
      t = round_keys[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end
      round_keys[i] = round_keys[i-4] ^ t;
    end
  endfunction

  // byte n of the state sits at [127-8n -: 8]
  function automatic logic [127:0] byte_subst(input logic [127:0] st, input logic inv);
    for (int n = 0; n < 16; n++)
      st[127-8*n -: 8] = inv ? sbox_rev[st[127-8*n -: 8]] : sbox_fwd[st[127-8*n -: 8]];
    return st;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] st, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
        t[127-8*(4*c+r) -: 8] = st[127-8*(4*src+r) -: 8];
      end
    return t;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] st, input logic inv);
    logic [127:0] t;
    aes128_pkg::byte_t coef [4];
    aes128_pkg::byte_t acc;
    if (inv) begin
      coef[0] = 8'd14; coef[1] = 8'd11; coef[2] = 8'd13; coef[3] = 8'd9;
    end else begin
      coef[0] = 8'd2; coef[1] = 8'd3; coef[2] = 8'd1; coef[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int j = 0; j < 4; j++)
          acc ^= gmul(st[127-8*(4*c+j) -: 8], coef[(j + 4 - r) & 3]);
        t[127-8*(4*c+r) -: 8] = acc;
      end
    return t;
  endfunction

  function automatic logic [127:0] key_xor(input logic [127:0] st, input int rnd);
    for (int c = 0; c < 4; c++)
      st[127-32*c -: 32] ^= round_keys[4*rnd+c];
    return st;
  endfunction

  function automatic logic [127:0] cipher_block(input logic [127:0] st, input logic op);
    if (op == aes128_pkg::OpEncrypt) begin
      st = key_xor(st, 0);
      for (int rnd = 1; rnd < aes128_pkg::Rounds; rnd++)
        st = key_xor(column_mix(row_rotate(byte_subst(st, 1'b0), 1'b0), 1'b0), rnd);
      st = key_xor(row_rotate(byte_subst(st, 1'b0), 1'b0), aes128_pkg::Rounds);
    end else begin
      st = key_xor(st, aes128_pkg::Rounds);
      for (int rnd = aes128_pkg::Rounds - 1; rnd >= 1; rnd--)
        st = column_mix(key_xor(byte_subst(row_rotate(st, 1'b1), 1'b1), rnd), 1'b1);
      st = key_xor(byte_subst(row_rotate(st, 1'b1), 1'b1), 0);
    end
    return st;
  endfunction

  initial begin
    errors_o = 0;
    key_hi = '0;
    key_lo = '0;
  end

  assign pending_o = block_q.size();

  always @(posedge clk_i) begin
    cipher_block_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == aes128_pkg::CfgKeyUpper) key_hi = cfg_data_i;
        else key_lo = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        build_round_keys();
        // tdata carries block_upper in the low half
        block_q.push_back(cipher_block(
          {s_tdata_i[63:0], s_tdata_i[127:64]}, s_tuser_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (block_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_tdata_i);
          errors_o++;
        end else begin
          want = block_q.pop_front();
          if (m_tdata_i[63:0] !== want.upper) begin
            $display("%0t: result_upper expected %h actual %h",
                     $realtime, want.upper, m_tdata_i[63:0]);
            errors_o++;
          end
          if (m_tdata_i[127:64] !== want.lower) begin
            $display("%0t: result_lower expected %h actual %h",
                     $realtime, want.lower, m_tdata_i[127:64]);
            errors_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_aes128_block_cipher_top.sv */
// top of the aes-128 testbench: clock, reset, key writes, block requests, verdict
`default_nettype none
module tb_aes128_block_cipher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = aes128_pkg::CfgKeyUpper;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = aes128_pkg::OpEncrypt;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  int           errors, pending;
  int           cycles = 0;
  logic         steady = 1'b0;  // no idling on either side while set

  always #10 clk_i = ~clk_i;

  aes128_block_cipher_top u_top (.*);

  aes128_cipher_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= steady || ($urandom_range(99) >= 22);

  // caller stands at a rising edge; returns at the edge the request is taken
  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    while (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {lo, hi};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // pending is sampled away from the rising edge so the last request is counted
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // key writes only once the block has gone idle
  task automatic write_key(input logic idx, input logic [63:0] value);
    drain();
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++)
      send_block(logic'($urandom_range(1)), rand64(), rand64());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero key straight after reset
    send_block(aes128_pkg::OpEncrypt, '0, '0);
    send_block(aes128_pkg::OpDecrypt, '0, '0);
    send_block(aes128_pkg::OpEncrypt, '1, '1);
    write_key(aes128_pkg::CfgKeyUpper, 64'h0001020304050607);
    write_key(aes128_pkg::CfgKeyLower, 64'h08090a0b0c0d0e0f);
    send_block(aes128_pkg::OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(aes128_pkg::OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(aes128_pkg::OpEncrypt, '0, '1);
    send_block(aes128_pkg::OpDecrypt, '1, '0);
    // only one half of the key changes
    write_key(aes128_pkg::CfgKeyLower, '1);
    send_block(aes128_pkg::OpEncrypt, 64'h8000000000000000, 64'h0000000000000001);
    send_block(aes128_pkg::OpDecrypt, 64'h8000000000000000, 64'h0000000000000001);
    write_key(aes128_pkg::CfgKeyUpper, '1);
    send_block(aes128_pkg::OpEncrypt, '1, '1);
    send_block(aes128_pkg::OpDecrypt, '1, '1);
    write_key(aes128_pkg::CfgKeyUpper, '0);
    write_key(aes128_pkg::CfgKeyLower, '0);
    send_block(aes128_pkg::OpDecrypt, 64'h0123456789abcdef, 64'hfedcba9876543210);

    for (int phase = 0; phase < 4; phase++) begin
      write_key(aes128_pkg::CfgKeyUpper, rand64());
      write_key(aes128_pkg::CfgKeyLower, rand64());
      steady = (phase == 2);
      random_phase(200);
      drain();
      @(posedge clk_i);
      random_phase(200);
    end
    steady = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/aes128_pkg.sv
sv/aes128_ram.sv
sv/aes128_round.sv
sv/aes128_block_cipher_top.sv
tb/aes128_cipher_checker.sv
tb/tb_aes128_block_cipher_top.sv
